@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the registration core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define DRC_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define DRC_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/core/drc_pkg.sv @@
// ---------------------------------------------------------------------------
// drc_pkg
// Types and constants shared by the depth-to-colour registration modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package drc_pkg;

   // Width of the projected sums: products stay below 2^59, four of them below 2^61.
   localparam int PW = 64;
   localparam int COEF_W = 32;
   localparam int DIM_W = 13;
   localparam int LIM_W = 15;

   localparam logic [15:0] DEF_MAX_DEPTH_MM = 16'd5000;
   localparam int DEF_COORD_BITS = 12;

   localparam logic [DIM_W-1:0] RST_WIDTH = 13'd640;
   localparam logic [DIM_W-1:0] RST_HEIGHT = 13'd480;

   typedef enum logic [2:0] {
      CSR_ROW0_XY = 3'd0,
      CSR_ROW0_ZB = 3'd1,
      CSR_ROW1_XY = 3'd2,
      CSR_ROW1_ZB = 3'd3,
      CSR_ROW2_XY = 3'd4,
      CSR_ROW2_ZB = 3'd5,
      CSR_WIDTH   = 3'd6,
      CSR_HEIGHT  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [2:0][2:0][COEF_W-1:0] a;
      logic [2:0][COEF_W-1:0] b;
   } coef_type;

   // Per-item flags that travel beside the divider.
   typedef struct packed {
      logic ok;
      logic neg0;
      logic neg1;
      logic [15:0] z;
   } side_type;

endpackage

@@ rtl/core/drc_front.sv @@
// ---------------------------------------------------------------------------
// drc_front
// Four-stage front end: depth products, coefficient products and the sums.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module drc_front #(
   parameter logic [15:0] MAX_DEPTH_MM = drc_pkg::DEF_MAX_DEPTH_MM
) (
   input  logic clock,
   input  logic [3:0] adv,
   input  logic [11:0] col,
   input  logic [11:0] row,
   input  logic [15:0] dep,
   input  drc_pkg::coef_type coef,
   output logic [2:0][drc_pkg::PW-1:0] p,
   output logic dok
);
   import drc_pkg::*;

   logic [27:0] cd_ff, rd_ff;
   logic [15:0] d_ff;
   logic dok1_ff, dok2_ff, dok3_ff, dok4_ff;
   logic signed [PW-1:0] prod_ff [3][3];
   logic signed [PW-1:0] bsh_ff [3];
   logic signed [PW-1:0] sa_ff [3];
   logic signed [PW-1:0] sb_ff [3];
   logic [2:0][PW-1:0] p_ff;

   // Stage one: depth range check and the column and row products.
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         cd_ff <= {16'd0, col} * {12'd0, dep};
         rd_ff <= {16'd0, row} * {12'd0, dep};
         d_ff <= dep;
         dok1_ff <= (dep != 16'd0) && (dep <= MAX_DEPTH_MM);
      end
   end

   // Stage two: the nine coefficient products, one multiplier each.
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         for (int r = 0; r < 3; r++) begin
            prod_ff[r][0] <= PW'($signed(coef.a[r][0]) * $signed({1'b0, cd_ff}));
            prod_ff[r][1] <= PW'($signed(coef.a[r][1]) * $signed({1'b0, rd_ff}));
            prod_ff[r][2] <= PW'($signed(coef.a[r][2]) * $signed({1'b0, d_ff}));
            bsh_ff[r] <= PW'($signed(coef.b[r])) <<< 8;
         end
         dok2_ff <= dok1_ff;
      end
   end

   // Stage three: pairwise sums.
   always_ff @(posedge clock) begin
      if (adv[2]) begin
         for (int r = 0; r < 3; r++) begin
            sa_ff[r] <= prod_ff[r][0] + prod_ff[r][1];
            sb_ff[r] <= prod_ff[r][2] + bsh_ff[r];
         end
         dok3_ff <= dok2_ff;
      end
   end

   // Stage four: final sums in Q.16.
   always_ff @(posedge clock) begin
      if (adv[3]) begin
         for (int r = 0; r < 3; r++) begin
            p_ff[r] <= sa_ff[r] + sb_ff[r];
         end
         dok4_ff <= dok3_ff;
      end
   end

   assign p = p_ff;
   assign dok = dok4_ff;

endmodule

@@ rtl/core/drc_div.sv @@
// ---------------------------------------------------------------------------
// drc_div
// Pipelined restoring divider for two dividends over one divisor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module drc_div #(
   parameter int QB = drc_pkg::DEF_COORD_BITS
) (
   input  logic clock,
   input  logic [QB-1:0] adv,
   input  logic [drc_pkg::PW-1:0] num0,
   input  logic [drc_pkg::PW-1:0] num1,
   input  logic [drc_pkg::PW-1:0] den,
   input  drc_pkg::side_type side_i,
   output logic [QB-1:0] quo0,
   output logic [QB-1:0] quo1,
   output drc_pkg::side_type side_o
);
   import drc_pkg::*;

   localparam int DW = PW + QB;

   logic [PW-1:0] rem0_ff [QB];
   logic [PW-1:0] rem1_ff [QB];
   logic [PW-1:0] den_ff [QB];
   logic [QB-1:0] q0_ff [QB];
   logic [QB-1:0] q1_ff [QB];
   side_type side_ff [QB];

   // Each stage settles one quotient bit, most significant first. The dividend
   // is known to be below the divisor shifted by QB, so QB stages suffice.
   for (genvar i = 0; i < QB; i++) begin : g_stage
      logic [PW-1:0] r0, r1, dv;
      logic [QB-1:0] qa, qb;
      side_type sd;
      logic [DW-1:0] sh, t0, t1;
      logic ge0, ge1;

      if (i == 0) begin : g_first
         assign r0 = num0;
         assign r1 = num1;
         assign dv = den;
         assign qa = '0;
         assign qb = '0;
         assign sd = side_i;
      end else begin : g_next
         assign r0 = rem0_ff[i-1];
         assign r1 = rem1_ff[i-1];
         assign dv = den_ff[i-1];
         assign qa = q0_ff[i-1];
         assign qb = q1_ff[i-1];
         assign sd = side_ff[i-1];
      end

      assign sh = {{QB{1'b0}}, dv} << (QB - 1 - i);
      assign t0 = {{QB{1'b0}}, r0} - sh;
      assign t1 = {{QB{1'b0}}, r1} - sh;
      assign ge0 = {{QB{1'b0}}, r0} >= sh;
      assign ge1 = {{QB{1'b0}}, r1} >= sh;

      always_ff @(posedge clock) begin
         if (adv[i]) begin
            rem0_ff[i] <= ge0 ? t0[PW-1:0] : r0;
            rem1_ff[i] <= ge1 ? t1[PW-1:0] : r1;
            q0_ff[i] <= {qa[QB-2:0], ge0};
            q1_ff[i] <= {qb[QB-2:0], ge1};
            den_ff[i] <= dv;
            side_ff[i] <= sd;
         end
      end
   end

   assign quo0 = q0_ff[QB-1];
   assign quo1 = q1_ff[QB-1];
   assign side_o = side_ff[QB-1];

endmodule

@@ rtl/core/depth_to_color_pixel_registration_core.sv @@
// ---------------------------------------------------------------------------
// depth_to_color_pixel_registration_core
// Maps depth pixels into the colour image frame, one pixel per clock while rsp_ is not stalled.
// ---------------------------------------------------------------------------
// The req_ channel carries one depth pixel per transfer (column, row and depth
// in millimetres); the rsp_ channel returns one result per pixel, in order,
// with a validity flag, the colour image column and row, and the depth seen
// from the colour camera. A transfer happens when valid is high and stall is
// low on that channel.
// The csr_ channel writes the projection coefficients and the target image
// size; csr_ready is always high. Writes are to be made only while idle; the
// block itself does not enforce this. From a req_ transfer to its result on
// rsp_, a pixel passes through the products and sums of the front end, the
// sign and range preparation, the pipelined divider stages for the quotient
// bits, and the output register.
// Throughput is one pixel per cycle while rsp_ is not stalled. Each stage holds a valid bit and loads
// whenever it is empty or the stage after it moves, so bubbles close up and
// a stall on rsp_ backs up stage by stage without losing or repeating items.
// Reset clears all valid bits and returns the configuration registers to their defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module depth_to_color_pixel_registration_core #(
   parameter logic [15:0] MAX_DEPTH_MM = drc_pkg::DEF_MAX_DEPTH_MM,
   parameter int COORD_BITS = drc_pkg::DEF_COORD_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [11:0] req_pixel_col,
   input  logic [11:0] req_pixel_row,
   input  logic [15:0] req_depth_mm,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_valid_res,
   output logic [11:0] rsp_target_col,
   output logic [11:0] rsp_target_row,
   output logic [15:0] rsp_target_depth_mm,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [63:0] csr_data
);
   import drc_pkg::*;

   // Stage map: 0..3 front end, 4 preparation, 5..4+QB divider, last is output.
   localparam int QB = COORD_BITS;
   localparam int NS = QB + 6;
   localparam int DIVS = 5;
   localparam logic [LIM_W-1:0] COORD_LIMIT = LIM_W'(1 << QB);
   localparam logic [11:0] COORD_MASK = 12'((1 << QB) - 1);

   // Configuration registers.
   logic [63:0] xy_ff [3];
   logic [63:0] zb_ff [3];
   logic [DIM_W-1:0] width_ff, height_ff;
   coef_type coef;

   // Pipeline control.
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] adv;

   // Datapath between the units.
   logic [2:0][PW-1:0] p;
   logic dok;
   logic [PW-1:0] mag0_ff, mag1_ff, den_ff;
   side_type side_ff, side_q;
   logic [QB-1:0] quo0, quo1;

   logic [PW-1:0] p0, p1, p2;
   logic [PW-1:0] mag0_in, mag1_in;
   logic p2_pos, in0, in1;
   logic [15:0] z_in;
   side_type side_in;

   logic [LIM_W-1:0] lim_w, lim_h;
   logic u_ok, v_ok, res_ok;

   logic res_ff;
   logic [11:0] col_ff, row_ff;
   logic [15:0] dep_ff;

   // The register file accepts a write in every cycle.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            xy_ff[r] <= '0;
            zb_ff[r] <= '0;
         end
         width_ff <= RST_WIDTH;
         height_ff <= RST_HEIGHT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROW0_XY: xy_ff[0] <= csr_data;
            CSR_ROW0_ZB: zb_ff[0] <= csr_data;
            CSR_ROW1_XY: xy_ff[1] <= csr_data;
            CSR_ROW1_ZB: zb_ff[1] <= csr_data;
            CSR_ROW2_XY: xy_ff[2] <= csr_data;
            CSR_ROW2_ZB: zb_ff[2] <= csr_data;
            CSR_WIDTH:   width_ff <= csr_data[DIM_W-1:0];
            CSR_HEIGHT:  height_ff <= csr_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         coef.a[r][0] = xy_ff[r][31:0];
         coef.a[r][1] = xy_ff[r][63:32];
         coef.a[r][2] = zb_ff[r][31:0];
         coef.b[r] = zb_ff[r][63:32];
      end
   end

   // A stage may load when it is empty or its contents move on this cycle.
   always_comb begin
      adv[NS-1] = !vld_ff[NS-1] || !rsp_stall;
      for (int k = NS - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= (k == 0) ? req_valid : vld_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = vld_ff[NS-1];

   drc_front #(
      .MAX_DEPTH_MM(MAX_DEPTH_MM)
   ) u_front (
      .clock(clock),
      .adv(adv[3:0]),
      .col(req_pixel_col & COORD_MASK),
      .row(req_pixel_row & COORD_MASK),
      .dep(req_depth_mm),
      .coef(coef),
      .p(p),
      .dok(dok)
   );

   // Preparation: sign of p2, magnitudes of p0 and p1, and a bound check that
   // keeps the quotients within COORD_BITS bits. The depth saturates here.
   always_comb begin
      p0 = p[0];
      p1 = p[1];
      p2 = p[2];
      p2_pos = !p2[PW-1] && (p2 != '0);
      mag0_in = p0[PW-1] ? (~p0 + 1'b1) : p0;
      mag1_in = p1[PW-1] ? (~p1 + 1'b1) : p1;
      in0 = {{QB{1'b0}}, mag0_in} < {p2, {QB{1'b0}}};
      in1 = {{QB{1'b0}}, mag1_in} < {p2, {QB{1'b0}}};
      z_in = (p2[PW-1:32] != '0) ? 16'hFFFF : p2[31:16];
      side_in.ok = dok && p2_pos && in0 && in1;
      side_in.neg0 = p0[PW-1];
      side_in.neg1 = p1[PW-1];
      side_in.z = z_in;
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         mag0_ff <= mag0_in;
         mag1_ff <= mag1_in;
         den_ff <= p2;
         side_ff <= side_in;
      end
   end

   drc_div #(
      .QB(QB)
   ) u_div (
      .clock(clock),
      .adv(adv[DIVS+QB-1:DIVS]),
      .num0(mag0_ff),
      .num1(mag1_ff),
      .den(den_ff),
      .side_i(side_ff),
      .quo0(quo0),
      .quo1(quo1),
      .side_o(side_q)
   );

   // Output stage: a negative dividend is only in the image when its quotient
   // truncates to zero; sizes above the coordinate range are clipped to it.
   always_comb begin
      lim_w = ({2'b00, width_ff} > COORD_LIMIT) ? COORD_LIMIT : {2'b00, width_ff};
      lim_h = ({2'b00, height_ff} > COORD_LIMIT) ? COORD_LIMIT : {2'b00, height_ff};
      u_ok = !(side_q.neg0 && (quo0 != '0)) && (LIM_W'(quo0) < lim_w);
      v_ok = !(side_q.neg1 && (quo1 != '0)) && (LIM_W'(quo1) < lim_h);
      res_ok = side_q.ok && u_ok && v_ok;
   end

   always_ff @(posedge clock) begin
      if (adv[NS-1]) begin
         res_ff <= res_ok;
         col_ff <= res_ok ? 12'(quo0) : 12'd0;
         row_ff <= res_ok ? 12'(quo1) : 12'd0;
         dep_ff <= res_ok ? side_q.z : 16'd0;
      end
   end

   assign rsp_valid_res = res_ff;
   assign rsp_target_col = col_ff;
   assign rsp_target_row = row_ff;
   assign rsp_target_depth_mm = dep_ff;

endmodule

@@ rtl/core/drc_checker.sv @@
// ---------------------------------------------------------------------------
// drc_checker
// Port-level checks on the registration core, attached by bind.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module drc_checker (
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_valid_res,
   input logic [11:0] rsp_target_col,
   input logic [11:0] rsp_target_row,
   input logic [15:0] rsp_target_depth_mm
);

   `DRC_ASSERT_NEXT(a_reset_empty, reset, !rsp_valid, "result valid after reset")

   `DRC_ASSERT_NOW(a_invalid_zero, rsp_valid && !rsp_valid_res,
      (rsp_target_col == 12'd0) && (rsp_target_row == 12'd0) && (rsp_target_depth_mm == 16'd0),
      "invalid result with non-zero fields")

   `DRC_ASSERT_NOW(a_empty_accepts, !reset && !rsp_valid, !req_stall,
      "input stalled while the pipeline drains freely")

   `DRC_ASSERT_NEXT(a_hold, !reset && rsp_valid && rsp_stall,
      reset || (rsp_valid && $stable(rsp_valid_res) && $stable(rsp_target_col)
      && $stable(rsp_target_row) && $stable(rsp_target_depth_mm)),
      "stalled result changed")

endmodule

bind depth_to_color_pixel_registration_core drc_checker u_drc_checker (.*);
